[src/dstf_pkg.sv]
// shared types, constants and the fraction weight table for the decimal
// string to fixed-point converter; no dependencies
package dstf_pkg;

	localparam int SYMBOL_W   = 8;
	localparam int VALUE_W    = 64;
	localparam int WEIGHT_W   = 32;
	localparam int WEIGHT_IDX_W = 4;
	localparam int DIGIT_W    = 4;

	localparam int DEF_FRACTION_BITS       = 32;
	localparam int DEF_MAX_FRACTION_DIGITS = 10;
	localparam int DEF_INTEGER_BITS        = 31;

	localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [SYMBOL_W-1:0] CHAR_DOT   = 8'h2e;
	localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2d;

	// result of one string, before the sign is applied
	typedef struct packed {
		logic               ok;
		logic               sat;
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} dstf_res_t;

	// floor(2^32 / 10^k), unsigned q0.32 weight of the k-th fraction digit
	function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [WEIGHT_IDX_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		case (k)
			4'd1:    w = 32'd429496729;
			4'd2:    w = 32'd42949672;
			4'd3:    w = 32'd4294967;
			4'd4:    w = 32'd429496;
			4'd5:    w = 32'd42949;
			4'd6:    w = 32'd4294;
			4'd7:    w = 32'd429;
			4'd8:    w = 32'd42;
			4'd9:    w = 32'd4;
			default: w = 32'd0;
		endcase
		return w;
	endfunction

endpackage

[src/decimal_string_to_fixed.sv]
// decimal text to signed q31.32 converter: one character per item, one result per string
// a string's result is registered in the result register, then in the output register
// throughput: one character per cycle; the scan stage holds only when a finished
// result finds both result registers full; reset (arst_n low) empties all stages
// and returns the scanner to the start of a string
module decimal_string_to_fixed
	import dstf_pkg::*;
#(
	parameter int FRACTION_BITS       = DEF_FRACTION_BITS,
	parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS,
	parameter int INTEGER_BITS        = DEF_INTEGER_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	// character stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SYMBOL_W-1:0] s_tdata,   // [7:0] symbol
	input  logic                s_tlast,   // last character of the string
	// result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [VALUE_W-1:0]  m_tdata,   // [63:0] value
	output logic [1:0]          m_tuser    // [0] valid_res, [1] overflow
);

	// handoff from the scanner to the sign stage
	logic      res_valid;
	logic      res_ready;
	dstf_res_t res;

	logic      out_ok;
	logic      out_sat;

	// input register, form check, accumulators and the per-string result register
	dstf_scan #(
		.FRACTION_BITS      (FRACTION_BITS),
		.MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS),
		.INTEGER_BITS       (INTEGER_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_symbol(s_tdata),
		.in_last  (s_tlast),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// two's complement negate for minus strings, then the output register
	dstf_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_ok   (out_ok),
		.out_sat  (out_sat),
		.out_value(m_tdata)
	);

	assign m_tuser = {out_sat, out_ok};

endmodule

[src/dstf_scan.sv]
// input register, form checker and integer/fraction accumulators;
// emits one registered dstf_res_t per string, depends on dstf_pkg
module dstf_scan
	import dstf_pkg::*;
#(
	parameter int FRACTION_BITS       = DEF_FRACTION_BITS,
	parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS,
	parameter int INTEGER_BITS        = DEF_INTEGER_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SYMBOL_W-1:0] in_symbol,
	input  logic                in_last,
	output logic                res_valid,
	input  logic                res_ready,
	output dstf_res_t           res
);

	localparam int FDW = $clog2(MAX_FRACTION_DIGITS + 1);
	localparam int IW  = INTEGER_BITS;

	localparam logic [2:0] PH_START  = 3'd0;
	localparam logic [2:0] PH_SIGNED = 3'd1;
	localparam logic [2:0] PH_INT    = 3'd2;
	localparam logic [2:0] PH_DOT    = 3'd3;
	localparam logic [2:0] PH_FRAC   = 3'd4;
	localparam logic [2:0] PH_BAD    = 3'd5;

	logic                valid_s1;
	logic [SYMBOL_W-1:0] symbol_s1;
	logic                last_s1;

	logic [2:0]          phase_q;
	logic                neg_q;
	logic [IW-1:0]       int_q;
	logic [WEIGHT_W-1:0] frac_q;
	logic [FDW-1:0]      fcnt_q;
	logic                sat_q;

	logic                res_valid_s2;
	dstf_res_t           res_s2;

	logic                s2_free, s1_fire;
	logic                num_char;
	logic [DIGIT_W-1:0]  digit;
	logic [IW+3:0]       int_ext, int_sum;
	logic                int_over;
	logic [FDW-1:0]      fcnt_inc;
	logic [WEIGHT_W-1:0] frac_prod;

	logic [2:0]          phase_n;
	logic                neg_n;
	logic [IW-1:0]       int_n;
	logic [WEIGHT_W-1:0] frac_n;
	logic [FDW-1:0]      fcnt_n;
	logic                sat_n;
	dstf_res_t           res_n;

	assign s2_free  = !res_valid_s2 || res_ready;
	assign s1_fire  = valid_s1 && (!last_s1 || s2_free);
	assign in_ready = !valid_s1 || s1_fire;

	assign num_char = (symbol_s1 >= CHAR_ZERO) && (symbol_s1 <= CHAR_NINE);
	assign digit    = num_char ? DIGIT_W'(symbol_s1 - CHAR_ZERO) : '0;

	// acc * 10 + d as (acc << 3) + (acc << 1) + d
	assign int_ext  = {4'b0, int_q};
	assign int_sum  = (int_ext << 3) + (int_ext << 1) + (IW+4)'(digit);
	assign int_over = |int_sum[IW+3:IW];

	// digit times weight always fits in the weight width
	assign fcnt_inc  = fcnt_q + FDW'(1);
	assign frac_prod = WEIGHT_W'(digit) * frac_weight(WEIGHT_IDX_W'(fcnt_inc));

	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		int_n   = int_q;
		frac_n  = frac_q;
		fcnt_n  = fcnt_q;
		sat_n   = sat_q;
		unique case (phase_q)
			PH_START, PH_SIGNED, PH_INT: begin
				if (num_char) begin
					phase_n = PH_INT;
					if (!sat_q) begin
						if (int_over) begin
							int_n = '1;
							sat_n = 1'b1;
						end else begin
							int_n = int_sum[IW-1:0];
						end
					end
				end else if (phase_q == PH_START && symbol_s1 == CHAR_MINUS) begin
					neg_n   = 1'b1;
					phase_n = PH_SIGNED;
				end else if (phase_q == PH_INT && symbol_s1 == CHAR_DOT) begin
					phase_n = PH_DOT;
				end else begin
					phase_n = PH_BAD;
				end
			end
			PH_DOT, PH_FRAC: begin
				if (num_char) begin
					phase_n = PH_FRAC;
					if (fcnt_q < FDW'(MAX_FRACTION_DIGITS)) begin
						fcnt_n = fcnt_inc;
						// total of all weighted digits stays below 2^32
						frac_n = frac_q + frac_prod;
					end
				end else begin
					phase_n = PH_BAD;
				end
			end
			default: phase_n = PH_BAD;
		endcase
	end

	// fraction never exceeds the low FRACTION_BITS, so the two parts just abut
	always_comb begin
		res_n.ok  = (phase_n == PH_FRAC);
		res_n.sat = res_n.ok && sat_n;
		res_n.neg = res_n.ok && neg_n;
		res_n.mag = '0;
		if (res_n.ok) begin
			res_n.mag = (VALUE_W'(int_n) << FRACTION_BITS) |
				VALUE_W'(frac_n >> (WEIGHT_W - FRACTION_BITS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			symbol_s1 <= in_symbol;
			last_s1   <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			fcnt_q  <= '0;
			sat_q   <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				int_q   <= '0;
				frac_q  <= '0;
				fcnt_q  <= '0;
				sat_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				int_q   <= int_n;
				frac_q  <= frac_n;
				fcnt_q  <= fcnt_n;
				sat_q   <= sat_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (s1_fire && last_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			res_s2 <= res_n;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

endmodule

[src/dstf_out.sv]
// sign stage and output register of the converter;
// depends on dstf_pkg
module dstf_out
	import dstf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	output logic               res_ready,
	input  dstf_res_t          res,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_ok,
	output logic               out_sat,
	output logic [VALUE_W-1:0] out_value
);

	logic               valid_q;
	logic               ok_q, sat_q;
	logic [VALUE_W-1:0] value_q;
	logic [VALUE_W-1:0] signed_val;

	assign res_ready  = !valid_q || out_ready;
	assign signed_val = res.neg ? (~res.mag + VALUE_W'(1)) : res.mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			ok_q    <= res.ok;
			sat_q   <= res.sat;
			value_q <= signed_val;
		end
	end

	assign out_valid = valid_q;
	assign out_ok    = ok_q;
	assign out_sat   = sat_q;
	assign out_value = value_q;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for decimal_string_to_fixed: streams number text through the
// character port and checks every string result against a local converter model
// or a typed probe row; depends on dstf_pkg and the decimal_string_to_fixed rtl
module testbench
	import dstf_pkg::*;
();

	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;   // idle time after the last expected result is taken
	localparam int REPORT_MAX   = 10;

	// scanner position inside one string
	typedef enum logic [2:0] {
		SCAN_START,
		SCAN_SIGN,
		SCAN_INT,
		SCAN_DOT,
		SCAN_FRAC,
		SCAN_REJECT
	} scan_t;

	typedef struct {
		bit               ok;
		bit               ovf;
		logic [VALUE_W-1:0] val;
	} conv_result_t;

	// one directed string; an empty text means a lone character given by code
	typedef struct {
		string        text;
		logic [7:0]   code;
		bit           typed;
		conv_result_t want;
	} probe_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [SYMBOL_W-1:0] s_tdata  = '0;
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [VALUE_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;

	// converter model state
	scan_t        scan;
	bit           neg;
	bit           sat;
	logic [63:0]  int_part;
	logic [63:0]  frac_sum;
	int           frac_cnt;

	conv_result_t expected_results[$];
	int           mismatches  = 0;
	int           sent_items  = 0;
	int           cycle_count = 0;
	bit           src_calm    = 1'b0;
	bit           snk_calm    = 1'b0;
	probe_row_t   probe_table [10];

	decimal_string_to_fixed DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL decimal_string_to_fixed");
		$finish;
	end

	function automatic void clear_scan();
		scan     = SCAN_START;
		neg      = 1'b0;
		sat      = 1'b0;
		int_part = '0;
		frac_sum = '0;
		frac_cnt = 0;
	endfunction

	// integer part grows by times ten and sticks at the top once it saturates
	function automatic void push_int_digit(input logic [63:0] d);
		logic [63:0] nxt;
		logic [63:0] top;
		top = (64'd1 << DEF_INTEGER_BITS) - 64'd1;
		if (!sat) begin
			nxt = int_part * 64'd10 + d;
			if (nxt > top) begin
				int_part = top;
				sat      = 1'b1;
			end else begin
				int_part = nxt;
			end
		end
	endfunction

	// advance the model by one character; done is set when a result comes out
	function automatic void absorb_symbol(input logic [7:0] c, input bit lst,
		output bit done, output conv_result_t res);
		bit          is_num;
		logic [63:0] d;
		logic [63:0] p;
		logic [63:0] mag;
		is_num = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
		d      = is_num ? {56'd0, c - CHAR_ZERO} : 64'd0;
		case (scan)
			SCAN_START: begin
				if (c == CHAR_MINUS) begin
					neg  = 1'b1;
					scan = SCAN_SIGN;
				end else if (is_num) begin
					push_int_digit(d);
					scan = SCAN_INT;
				end else begin
					scan = SCAN_REJECT;
				end
			end
			SCAN_SIGN: begin
				if (is_num) begin
					push_int_digit(d);
					scan = SCAN_INT;
				end else begin
					scan = SCAN_REJECT;
				end
			end
			SCAN_INT: begin
				if (is_num)
					push_int_digit(d);
				else if (c == CHAR_DOT)
					scan = SCAN_DOT;
				else
					scan = SCAN_REJECT;
			end
			SCAN_DOT, SCAN_FRAC: begin
				if (is_num) begin
					// digits past the table depth are checked for form only
					if (frac_cnt < DEF_MAX_FRACTION_DIGITS) begin
						frac_cnt++;
						p = 64'd1;
						for (int i = 0; i < frac_cnt; i++)
							p = p * 64'd10;
						frac_sum = frac_sum + d * ((64'd1 << WEIGHT_W) / p);
					end
					scan = SCAN_FRAC;
				end else begin
					scan = SCAN_REJECT;
				end
			end
			default: scan = SCAN_REJECT;
		endcase
		done = lst;
		res  = '{1'b0, 1'b0, 64'd0};
		if (lst) begin
			if (scan == SCAN_FRAC) begin
				mag = (int_part << DEF_FRACTION_BITS) +
					(frac_sum >> (WEIGHT_W - DEF_FRACTION_BITS));
				res.ok  = 1'b1;
				res.ovf = sat;
				res.val = neg ? (64'd0 - mag) : mag;
			end
			clear_scan();
		end
	endfunction

	// present one character after a random gap and wait for it to be taken
	task automatic send_symbol(input logic [7:0] c, input bit lst, input bit typed,
		input conv_result_t want);
		int           gap;
		bit           done;
		conv_result_t got;
		if ($urandom_range(0, 63) == 0)
			src_calm = !src_calm;
		gap = src_calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		absorb_symbol(c, lst, done, got);
		if (done)
			expected_results.push_back(typed ? want : got);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	// result side: random ready gaps, compare each taken item with the oldest expectation
	initial begin
		int           gap;
		conv_result_t want;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				snk_calm = !snk_calm;
			gap = snk_calm ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (expected_results.size() == 0) begin
				note_mismatch($sformatf("result with nothing expected: ok %0b ovf %0b value %h",
					m_tuser[0], m_tuser[1], m_tdata));
			end else begin
				want = expected_results.pop_front();
				if (m_tuser[0] !== want.ok || m_tuser[1] !== want.ovf ||
					m_tdata !== want.val)
					note_mismatch($sformatf(
						"expected ok %0b ovf %0b value %h, got ok %0b ovf %0b value %h",
						want.ok, want.ovf, want.val, m_tuser[0], m_tuser[1], m_tdata));
			end
			@(negedge clk);
		end
	end

	initial begin
		logic [7:0]   txt[$];
		conv_result_t none;
		string        edge_digits;
		int           base;
		int           kind;
		int           n;
		int           pos;
		none        = '{1'b0, 1'b0, 64'd0};
		edge_digits = "214748364";
		clear_scan();

		// zero, negative zero, form errors in all but the fraction phase, odd codes,
		// and one string that saturates the integer and runs past the fraction table
		probe_table = '{
			'{"0.0",                     8'h00, 1'b1, '{1'b1, 1'b0, 64'd0}},
			'{"-0.0",                    8'h00, 1'b1, '{1'b1, 1'b0, 64'd0}},
			'{"1..",                     8'h00, 1'b1, none},
			'{"",                        8'h00, 1'b1, none},
			'{"",                        8'hff, 1'b1, none},
			'{"-",                       8'h00, 1'b1, none},
			'{"5.",                      8'h00, 1'b1, none},
			'{".5",                      8'h00, 1'b1, none},
			'{"9:",                      8'h00, 1'b1, none},
			'{"-9999999999.12345678901", 8'h00, 1'b0, none}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (probe_table[i]) begin
			if (probe_table[i].text.len() == 0) begin
				send_symbol(probe_table[i].code, 1'b1, probe_table[i].typed, probe_table[i].want);
			end else begin
				for (int j = 0; j < probe_table[i].text.len(); j++)
					send_symbol(probe_table[i].text[j], j == probe_table[i].text.len() - 1,
						probe_table[i].typed, probe_table[i].want);
			end
		end

		// random strings: mostly well formed, some broken, a few pure noise
		base = sent_items;
		while (sent_items - base < RANDOM_ITEMS) begin
			txt.delete();
			kind = $urandom_range(0, 99);
			if (kind < 90) begin
				if ($urandom_range(0, 1))
					txt.push_back(CHAR_MINUS);
				if ($urandom_range(0, 15) == 0) begin
					// right around the saturation point
					for (int j = 0; j < edge_digits.len(); j++)
						txt.push_back(edge_digits[j]);
					txt.push_back(CHAR_ZERO + 8'($urandom_range(6, 9)));
				end else begin
					n = $urandom_range(0, 99);
					n = (n < 80) ? $urandom_range(1, 4) :
						(n < 95) ? $urandom_range(5, 10) : $urandom_range(11, 14);
					repeat (n) txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
				end
				txt.push_back(CHAR_DOT);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3);
				repeat (n) txt.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
				if (kind >= 70) begin
					pos = $urandom_range(0, txt.size() - 1);
					case ($urandom_range(0, 3))
						0: txt[pos] = 8'($urandom_range(0, 255));
						1: txt.insert(pos, $urandom_range(0, 1) ? CHAR_DOT : CHAR_MINUS);
						2: while (txt.size() > pos + 1) txt.pop_back();
						default: txt.push_front(8'($urandom_range(0, 255)));
					endcase
				end
			end else begin
				repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom_range(0, 255)));
			end
			foreach (txt[j])
				send_symbol(txt[j], j == txt.size() - 1, 1'b0, none);
		end
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS decimal_string_to_fixed");
		else
			$display("FAIL decimal_string_to_fixed");
		$finish;
	end

endmodule

[files.f]
src/dstf_pkg.sv
src/dstf_scan.sv
src/dstf_out.sv
src/decimal_string_to_fixed.sv
tb/sv/testbench.sv
